// ===== rtl/core/lact_pkg.sv =====
`timescale 1ns / 1ps
package lact_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int TIME_BITS_DEF     = 32;
  localparam int MIN_W             = 11;
  localparam int AGE_W             = 32;
  localparam int IDX_W             = 10;
  localparam int REQ_TIME_W        = 32;
  localparam int CNT_OUT_W         = 11;
  localparam int OLD_OUT_W         = 32;
  localparam int IN_DATA_W         = 48;
  localparam int OUT_DATA_W        = 56;
  localparam int CFG_ADDR_W        = 1;
  localparam int CFG_DATA_W        = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_ENTRIES = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_AGE     = 1'd1;

  localparam logic [MIN_W-1:0] MIN_ENTRIES_RST = 11'd0;
  localparam logic [AGE_W-1:0] MAX_AGE_RST     = 32'd60;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_PUSH1,
    ST_PUSH2,
    ST_EVCHK,
    ST_EVCMP,
    ST_EVRD,
    ST_FIN
  } lact_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_LOOK,
    OP_PUSH1,
    OP_PUSH2,
    OP_EVCHK,
    OP_EVRD,
    OP_EVCMP,
    OP_LOAD
  } lact_op_t;

  typedef struct packed {
    lact_op_t op;
  } lact_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic was_active;
    logic at_head;
    logic evict_now;
    logic tail_null;
    logic out_full;
  } lact_stat_t;

endpackage

// ===== rtl/core/lact_ram.sv =====
`timescale 1ns / 1ps
module lact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lact_ctrl.sv =====
`timescale 1ns / 1ps
module lact_ctrl
  import lact_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  lact_stat_t stat,
  output lact_cmd_t  cmd
);

  lact_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.op = OP_LOOK;
        if (!stat.was_active || !stat.at_head) state_nxt = ST_PUSH1;
        else state_nxt = ST_EVCHK;
      end
      ST_PUSH1: begin
        cmd.op    = OP_PUSH1;
        state_nxt = ST_PUSH2;
      end
      ST_PUSH2: begin
        cmd.op    = OP_PUSH2;
        state_nxt = ST_EVCHK;
      end
      ST_EVCHK: begin
        cmd.op    = OP_EVCHK;
        state_nxt = ST_EVCMP;
      end
      ST_EVCMP: begin
        cmd.op = OP_EVCMP;
        if (stat.evict_now) state_nxt = ST_EVRD;
        else state_nxt = ST_FIN;
      end
      ST_EVRD: begin
        if (stat.tail_null) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.op    = OP_EVRD;
          state_nxt = ST_EVCMP;
        end
      end
      ST_FIN: begin
        if (!stat.out_full) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/core/lact_dp.sv =====
`timescale 1ns / 1ps
module lact_dp
  import lact_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lact_cmd_t             cmd,
  output lact_stat_t            stat,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int LW = $clog2(TABLE_ENTRIES + 1);
  localparam int MW = (LW > MIN_W) ? LW : MIN_W;
  localparam int CW = (TIME_BITS > AGE_W) ? TIME_BITS : AGE_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(TABLE_ENTRIES);

  function automatic logic [IW-1:0] reduce_idx(input logic [IDX_W-1:0] v);
    logic [31:0] acc;
    acc = 32'(v);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if ((longint'(TABLE_ENTRIES) << k) < (longint'(1) << IDX_W)) begin
        if (acc >= (32'(TABLE_ENTRIES) << k)) acc = acc - (32'(TABLE_ENTRIES) << k);
      end
    end
    return IW'(acc);
  endfunction

  logic [MIN_W-1:0]     min_r;
  logic [AGE_W-1:0]     age_r;
  logic [IW-1:0]        s_r;
  logic [TIME_BITS-1:0] now_r;
  logic [LW-1:0]        head_r, tail_r, cnt_r, evicted_r;
  logic [TIME_BITS-1:0] oldest_r;
  logic                 new_r, en_r;
  logic [IW-1:0]        clr_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                 act_q;
  logic [TIME_BITS-1:0] time_q;
  logic [LW-1:0]        prev_q, next_q;

  logic                 act_we, act_wd, act_re;
  logic [IW-1:0]        act_wa, act_ra;
  logic                 time_we, time_re;
  logic [IW-1:0]        time_ra;
  logic                 prev_we, prev_re;
  logic [IW-1:0]        prev_wa, prev_ra;
  logic [LW-1:0]        prev_wd;
  logic                 next_we, next_re;
  logic [IW-1:0]        next_wa, next_ra;
  logic [LW-1:0]        next_wd;

  logic [IW-1:0]        s_in;
  logic [LW-1:0]        s_link;
  logic                 unlink;
  logic                 too_old;
  logic [CW-1:0]        diff;

  assign s_in   = reduce_idx(in_tdata[IDX_W-1:0]);
  assign s_link = LW'(s_r);
  assign unlink = act_q && (head_r != s_link);
  assign diff   = CW'(now_r) - CW'(time_q);
  assign too_old = (time_q < now_r) && (diff > CW'(age_r));

  assign stat.clr_last   = (clr_r == IW'(TABLE_ENTRIES - 1));
  assign stat.was_active = act_q;
  assign stat.at_head    = (head_r == s_link);
  assign stat.evict_now  = en_r && too_old;
  assign stat.tail_null  = (tail_r == NULL_LINK);
  assign stat.out_full   = out_valid_r && !out_tready;

  always_comb begin
    act_we  = 1'b0; act_wa  = s_r;  act_wd = 1'b0;
    act_re  = 1'b0; act_ra  = s_in;
    time_we = 1'b0; time_re = 1'b0; time_ra = tail_r[IW-1:0];
    prev_we = 1'b0; prev_wa = s_r;  prev_wd = NULL_LINK;
    prev_re = 1'b0; prev_ra = s_in;
    next_we = 1'b0; next_wa = s_r;  next_wd = NULL_LINK;
    next_re = 1'b0; next_ra = s_in;
    case (cmd.op)
      OP_CLEAR: begin
        act_we = 1'b1; act_wa = clr_r; act_wd = 1'b0;
      end
      OP_ACCEPT: begin
        act_re  = 1'b1;
        prev_re = 1'b1;
        next_re = 1'b1;
      end
      OP_LOOK: begin
        time_we = 1'b1;
        if (!act_q) begin
          act_we = 1'b1; act_wd = 1'b1;
        end else if (unlink) begin
          if (next_q != NULL_LINK) begin
            prev_we = 1'b1; prev_wa = next_q[IW-1:0]; prev_wd = prev_q;
          end
          if (prev_q != NULL_LINK) begin
            next_we = 1'b1; next_wa = prev_q[IW-1:0]; next_wd = next_q;
          end
        end
      end
      OP_PUSH1: begin
        next_we = 1'b1; next_wa = s_r; next_wd = head_r;
        if (head_r != NULL_LINK) begin
          prev_we = 1'b1; prev_wa = head_r[IW-1:0]; prev_wd = s_link;
        end
      end
      OP_PUSH2: begin
        prev_we = 1'b1; prev_wa = s_r; prev_wd = NULL_LINK;
      end
      OP_EVCHK, OP_EVRD: begin
        time_re = 1'b1;
        prev_re = 1'b1; prev_ra = tail_r[IW-1:0];
      end
      OP_EVCMP: begin
        if (en_r && too_old) begin
          act_we = 1'b1; act_wa = tail_r[IW-1:0]; act_wd = 1'b0;
          if (prev_q != NULL_LINK) begin
            next_we = 1'b1; next_wa = prev_q[IW-1:0]; next_wd = NULL_LINK;
          end
        end
      end
      default: ;
    endcase
  end

  lact_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_act_ram (
    .clk(clk), .we(act_we), .waddr(act_wa), .wdata(act_wd),
    .re(act_re), .raddr(act_ra), .rdata(act_q)
  );

  lact_ram #(.WIDTH(TIME_BITS), .DEPTH(TABLE_ENTRIES)) u_time_ram (
    .clk(clk), .we(time_we), .waddr(s_r), .wdata(now_r),
    .re(time_re), .raddr(time_ra), .rdata(time_q)
  );

  lact_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .re(prev_re), .raddr(prev_ra), .rdata(prev_q)
  );

  lact_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .re(next_re), .raddr(next_ra), .rdata(next_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= MIN_ENTRIES_RST;
      age_r       <= MAX_AGE_RST;
      head_r      <= NULL_LINK;
      tail_r      <= NULL_LINK;
      cnt_r       <= '0;
      oldest_r    <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      en_r        <= 1'b0;
      new_r       <= 1'b0;
      evicted_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MIN_ENTRIES: min_r <= cfg_wdata[MIN_W-1:0];
          REG_MAX_AGE:     age_r <= cfg_wdata[AGE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_CLEAR: clr_r <= clr_r + 1'b1;
        OP_ACCEPT: begin
          s_r       <= s_in;
          now_r     <= TIME_BITS'(in_tdata[IDX_W +: REQ_TIME_W]);
          new_r     <= 1'b0;
          evicted_r <= '0;
        end
        OP_LOOK: begin
          if (!act_q) begin
            cnt_r <= cnt_r + 1'b1;
            new_r <= 1'b1;
          end else if (unlink) begin
            if (prev_q == NULL_LINK) head_r <= next_q;
            if (next_q == NULL_LINK) tail_r <= prev_q;
          end
        end
        OP_PUSH1: if (head_r == NULL_LINK) tail_r <= s_link;
        OP_PUSH2: head_r <= s_link;
        OP_EVCHK: en_r <= (MW'(cnt_r) > MW'(min_r));
        OP_EVCMP: begin
          if (en_r && too_old) begin
            if (prev_q == NULL_LINK) head_r <= NULL_LINK;
            tail_r    <= prev_q;
            if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
            evicted_r <= evicted_r + 1'b1;
          end else begin
            oldest_r <= time_q;
          end
        end
        OP_LOAD: begin
          out_data_r  <= OUT_DATA_W'({OLD_OUT_W'(oldest_r), CNT_OUT_W'(evicted_r),
                                      CNT_OUT_W'(cnt_r), new_r});
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/lru_aging_client_table.sv =====
`timescale 1ns / 1ps
// Recency table of client slots with age-based eviction from the tail.
// Input channel in_*: one request item per handshake; tdata carries the
// client slot and the request timestamp. Output channel out_*: exactly one
// result item per request, held in an output register until taken.
// Config port cfg_*: register 0 is min_entries, register 1 is max_age;
// write only while no request is in flight.
// Steps for a slot moved or inserted: accept, look-up, two push steps,
// eviction check, compare, finish; a slot already at the head skips the
// push steps, and each evicted entry adds a tail read and a compare.
// One request is in work at a time; the next is taken the cycle after the
// result is loaded. The link memories (prev, next) have one write and one
// registered read port each; the tail walk reads one entry at a time.
// Reset: a clearing pass marks every slot inactive, one slot per cycle,
// with in_tready low; config writes are taken.
// Stall: if out_tready is low with a result pending, the next result waits
// in the finish step and no further request is accepted.
module lru_aging_client_table
  import lact_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // client_index[9:0], request_time[41:10]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // was_new[0], active_count[11:1],
                                            // evicted_count[22:12], oldest_time[54:23]
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  lact_cmd_t  cmd;
  lact_stat_t stat;

  lact_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  lact_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one in work");

  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:1] != 11'd0)
    else $error("empty list after a request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[11:1]) <= 32'(TABLE_ENTRIES))
    else $error("active count beyond table size");

endmodule
